FILE: hdl/u16u8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and the code point encoder shared by the UTF-16 to UTF-8
// converter.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned UnitW       = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CpW         = 21;
  localparam int unsigned SurrBitsW   = 10;
  localparam int unsigned JobBytes    = 6;
  localparam int unsigned CpBytes     = 4;
  localparam int unsigned CountW      = 3;
  localparam int unsigned QueueDepth  = 2;

  // Upper six bits of a surrogate unit
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;

  localparam logic [CpW-1:0] SuppBase = 21'h10000;
  localparam logic [CpW-1:0] Lim1Byte = 21'h00080;
  localparam logic [CpW-1:0] Lim2Byte = 21'h00800;
  localparam logic [CpW-1:0] Lim3Byte = 21'h10000;

  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             string_done;
  } out_req_t;

  // Bytes of one code point, byte 0 goes out first
  typedef struct packed {
    logic [CpBytes-1:0][ByteW-1:0] bytes;
    logic [CountW-1:0]             len;
  } cp_enc_t;

  // All bytes one input unit produces, byte 0 goes out first
  typedef struct packed {
    logic [JobBytes-1:0][ByteW-1:0] bytes;
    logic [CountW-1:0]              count;
    logic                           eos;
  } job_t;

  function automatic cp_enc_t encode_cp(input logic [CpW-1:0] cp);
    cp_enc_t e;
    e.bytes = '0;
    if (cp < Lim1Byte) begin
      e.bytes[0] = cp[ByteW-1:0];
      e.len      = CountW'(1);
    end else if (cp < Lim2Byte) begin
      e.bytes[0] = {Lead2Tag, cp[10:6]};
      e.bytes[1] = {ContTag, cp[5:0]};
      e.len      = CountW'(2);
    end else if (cp < Lim3Byte) begin
      e.bytes[0] = {Lead3Tag, cp[15:12]};
      e.bytes[1] = {ContTag, cp[11:6]};
      e.bytes[2] = {ContTag, cp[5:0]};
      e.len      = CountW'(3);
    end else begin
      e.bytes[0] = {Lead4Tag, cp[20:18]};
      e.bytes[1] = {ContTag, cp[17:12]};
      e.bytes[2] = {ContTag, cp[11:6]};
      e.bytes[3] = {ContTag, cp[5:0]};
      e.len      = CountW'(4);
    end
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/u16u8_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and builds the byte job for each unit.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   src_ready,
  input  wire u16u8_pkg::in_req_t src_data,
  input  wire logic              queue_full,
  output logic                   push,
  output u16u8_pkg::job_t        job
);

  logic                                held_valid;
  logic                                held_valid_next;
  logic [u16u8_pkg::SurrBitsW-1:0]     held_high_bits;
  logic [u16u8_pkg::SurrBitsW-1:0]     held_high_bits_next;

  logic is_high, is_low, pair, flush, hold_new, emit_unit, accept;
  logic [u16u8_pkg::CpW-1:0] cp_a;
  u16u8_pkg::cp_enc_t enc_a, enc_b;

  assign src_ready = !queue_full;
  assign accept    = src_valid && src_ready;

  assign is_high   = src_data.code_unit[15:10] == u16u8_pkg::HighSurrTag;
  assign is_low    = src_data.code_unit[15:10] == u16u8_pkg::LowSurrTag;
  assign pair      = held_valid && is_low;
  assign flush     = held_valid && !is_low;
  assign hold_new  = !pair && is_high && !src_data.end_of_string;
  assign emit_unit = !pair && !hold_new && (src_data.code_unit != '0);

  // Either the combined supplementary code point or the held surrogate alone
  assign cp_a  = pair ? u16u8_pkg::SuppBase + {1'b0, held_high_bits, src_data.code_unit[9:0]}
                      : {5'b0, u16u8_pkg::HighSurrTag, held_high_bits};
  assign enc_a = u16u8_pkg::encode_cp(cp_a);
  assign enc_b = u16u8_pkg::encode_cp({5'b0, src_data.code_unit});

  always_comb begin
    job       = '0;
    job.eos   = src_data.end_of_string;
    if (pair) begin
      job.bytes[3:0] = enc_a.bytes;
      job.count      = enc_a.len;
    end else if (flush) begin
      job.bytes[2:0] = enc_a.bytes[2:0];
      if (emit_unit) begin
        job.bytes[5:3] = enc_b.bytes[2:0];
        job.count      = enc_a.len + enc_b.len;
      end else begin
        job.count = enc_a.len;
      end
    end else if (emit_unit) begin
      job.bytes[2:0] = enc_b.bytes[2:0];
      job.count      = enc_b.len;
    end
  end

  // Drop units that produce no bytes
  assign push = accept && (job.count != '0);

  always_comb begin
    held_valid_next     = held_valid;
    held_high_bits_next = held_high_bits;
    if (accept) begin
      held_valid_next = hold_new;
      if (hold_new) begin
        held_high_bits_next = src_data.code_unit[9:0];
      end else begin
        held_high_bits_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_bits <= '0;
    end else begin
      held_valid     <= held_valid_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/u16u8_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int unsigned Depth = u16u8_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire u16u8_pkg::job_t push_job,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output u16u8_pkg::job_t      head_job
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u16u8_pkg::job_t slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;

  assign full      = fill == CntW'(Depth);
  assign not_empty = fill != '0;
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/u16u8_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_back
// Walks each job one byte a cycle while dst_ready is high and drives the output channel.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            queue_not_empty,
  input  wire u16u8_pkg::job_t head_job,
  output logic                 pop,
  output logic                 dst_valid,
  input  wire logic            dst_ready,
  output u16u8_pkg::out_req_t  dst_data
);

  logic                           cur_valid;
  logic                           cur_valid_next;
  u16u8_pkg::job_t                cur;
  logic [u16u8_pkg::CountW-1:0]   idx;
  logic [u16u8_pkg::CountW-1:0]   idx_next;
  logic                           last, taken;

  assign last  = idx == (cur.count - 1'b1);
  assign taken = cur_valid && dst_ready;
  assign pop   = queue_not_empty && (!cur_valid || (taken && last));

  assign dst_valid            = cur_valid;
  assign dst_data.out_byte    = cur.bytes[idx];
  assign dst_data.run_last    = last;
  assign dst_data.string_done = last && cur.eos;

  always_comb begin
    cur_valid_next = cur_valid;
    idx_next       = idx;
    if (pop) begin
      cur_valid_next = 1'b1;
      idx_next       = '0;
    end else if (taken) begin
      if (last) begin
        cur_valid_next = 1'b0;
        idx_next       = '0;
      end else begin
        idx_next = idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      cur_valid <= cur_valid_next;
      idx       <= idx_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/utf16le_to_utf8_converter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf16le_to_utf8_converter_top
// UTF-16 code units in, UTF-8 bytes out, surrogate pairs combined.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  src      src_valid/src_ready    code_unit[15:0], end_of_string
//  dst      dst_valid/dst_ready    out_byte[7:0], run_last, string_done
//
//  The front takes one code unit per cycle while the job queue has room.
//  The back sends one byte per cycle while dst_ready is high, so sustained
//  throughput is set by the single output byte lane; a unit's first byte
//  passes through a queue slot and then the back's current-job register.
//  Synchronous reset clears the held surrogate, the queue and the back part.
//  A stalled dst fills the queue, then src_ready drops; zero units and held
//  high surrogates are taken without entering the queue.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_converter_top #(
  parameter int unsigned QueueDepth = u16u8_pkg::QueueDepth
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                src_valid,
  output logic                     src_ready,
  input  wire u16u8_pkg::in_req_t  src_data,
  output logic                     dst_valid,
  input  wire logic                dst_ready,
  output u16u8_pkg::out_req_t      dst_data
);

  // Front to queue
  logic            push;
  logic            queue_full;
  u16u8_pkg::job_t push_job;

  // Queue to back
  logic            pop;
  logic            queue_not_empty;
  u16u8_pkg::job_t head_job;

  // Classify the unit, pair surrogates, build the byte job
  u16u8_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_data   (src_data),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  // Hold jobs so each side can stall on its own
  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_job  (head_job)
  );

  // Advance through each job one byte per accepted request
  u16u8_back u_back (
    .clk             (clk),
    .rst             (rst),
    .queue_not_empty (queue_not_empty),
    .head_job        (head_job),
    .pop             (pop),
    .dst_valid       (dst_valid),
    .dst_ready       (dst_ready),
    .dst_data        (dst_data)
  );

endmodule
`default_nettype wire

FILE: verif/utf16le_to_utf8_converter_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf16le_to_utf8_converter_top_tb
// Self-checking bench for the UTF-16 to UTF-8 converter. Code unit requests
// are queued up front, driven with random gaps and checked byte by byte
// against a transcoder model that runs as each unit is accepted.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_converter_top_tb;

  // Least count of random code units added on top of the directed ones
  localparam int RandomUnits = 324;
  // Cycles to hold after the last expected byte before the verdict
  localparam int DrainCycles = 20;

  logic                clk;
  logic                rst       = 1'b1;
  logic                src_valid = 1'b0;
  logic                src_ready;
  u16u8_pkg::in_req_t  src_data  = '0;
  logic                dst_valid;
  logic                dst_ready = 1'b0;
  u16u8_pkg::out_req_t dst_data;

  utf16le_to_utf8_converter_top DUT (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_data (src_data),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_data (dst_data)
  );

  // Code unit requests waiting to be driven, filled before reset drops
  u16u8_pkg::in_req_t  pending_units[$];
  // UTF-8 byte requests the converter still owes, oldest first
  u16u8_pkg::out_req_t expected_bytes[$];
  // Bytes of the code points completed by the unit being modeled
  logic [7:0]          utf8_scratch[$];

  // Model state: a high surrogate waiting for its partner
  bit         surr_held      = 1'b0;
  logic [9:0] surr_high_bits = '0;

  int mismatches = 0;

  // Idle state of both sides; a calm side does not idle at all
  int src_gap   = 0;
  bit src_calm  = 1'b0;
  int dst_stall = 0;
  bit dst_calm  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Transcoder model
  // --------------------------------------------------------------------------

  // Append the UTF-8 form of one code point to the scratch buffer
  task automatic append_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      utf8_scratch.insert(utf8_scratch.size(), cp[7:0]);
    end else if (cp < 21'h800) begin
      utf8_scratch.insert(utf8_scratch.size(), 8'hC0 | 8'(cp >> 6));
      utf8_scratch.insert(utf8_scratch.size(), 8'h80 | (8'(cp) & 8'h3F));
    end else if (cp < 21'h10000) begin
      utf8_scratch.insert(utf8_scratch.size(), 8'hE0 | 8'(cp >> 12));
      utf8_scratch.insert(utf8_scratch.size(), 8'h80 | (8'(cp >> 6) & 8'h3F));
      utf8_scratch.insert(utf8_scratch.size(), 8'h80 | (8'(cp) & 8'h3F));
    end else begin
      utf8_scratch.insert(utf8_scratch.size(), 8'hF0 | (8'(cp >> 18) & 8'h07));
      utf8_scratch.insert(utf8_scratch.size(), 8'h80 | (8'(cp >> 12) & 8'h3F));
      utf8_scratch.insert(utf8_scratch.size(), 8'h80 | (8'(cp >> 6) & 8'h3F));
      utf8_scratch.insert(utf8_scratch.size(), 8'h80 | (8'(cp) & 8'h3F));
    end
  endtask

  // Advance the model by one accepted unit and queue the bytes it owes
  task automatic predict_utf8(input u16u8_pkg::in_req_t req);
    logic [15:0]         unit;
    bit                  is_high;
    bit                  is_low;
    u16u8_pkg::out_req_t exp_byte;
    int                  n;
    unit    = req.code_unit;
    is_high = (unit >= 16'hD800) && (unit <= 16'hDBFF);
    is_low  = (unit >= 16'hDC00) && (unit <= 16'hDFFF);
    utf8_scratch.delete();
    if (surr_held && is_low) begin
      append_utf8(21'h10000 + {surr_high_bits, 10'h000} + 21'(unit - 16'hDC00));
      surr_held = 1'b0;
    end else begin
      // A held high surrogate without a partner goes out alone first
      if (surr_held) begin
        append_utf8(21'hD800 + 21'(surr_high_bits));
        surr_held = 1'b0;
      end
      if (is_high && !req.end_of_string) begin
        surr_held      = 1'b1;
        surr_high_bits = unit[9:0];
      end else if (unit != 16'h0000) begin
        append_utf8(21'(unit));
      end
    end
    n = utf8_scratch.size();
    for (int k = 0; k < n; k++) begin
      exp_byte.out_byte    = utf8_scratch[k];
      exp_byte.run_last    = (k == n - 1);
      exp_byte.string_done = (k == n - 1) && req.end_of_string;
      expected_bytes.insert(expected_bytes.size(), exp_byte);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic push_unit(input logic [15:0] unit, input bit eos);
    u16u8_pkg::in_req_t req;
    req.code_unit     = unit;
    req.end_of_string = eos;
    pending_units.insert(pending_units.size(), req);
  endtask

  // A non-zero unit that is not a surrogate, spread over the 1-, 2- and 3-byte lengths
  function automatic logic [15:0] pick_scalar();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(16'h0001, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  // Mostly well-formed strings, some with lone surrogates, zeros and junk
  task automatic add_random_string();
    logic [15:0] units[$];
    int          len;
    bit          noisy;
    len   = $urandom_range(1, 8);
    noisy = ($urandom_range(0, 99) < 25);
    for (int i = 0; i < len; i++) begin
      if (!noisy) begin
        if ($urandom_range(0, 99) < 30) begin
          units.insert(units.size(), 16'hD800 + 16'($urandom_range(0, 16'h03FF)));
          units.insert(units.size(), 16'hDC00 + 16'($urandom_range(0, 16'h03FF)));
        end else begin
          units.insert(units.size(), pick_scalar());
        end
      end else begin
        case ($urandom_range(0, 4))
          0:       units.insert(units.size(), 16'($urandom()));
          1:       units.insert(units.size(), 16'hD800 + 16'($urandom_range(0, 16'h03FF)));
          2:       units.insert(units.size(), 16'hDC00 + 16'($urandom_range(0, 16'h03FF)));
          3:       units.insert(units.size(), 16'h0000);
          default: units.insert(units.size(), pick_scalar());
        endcase
      end
    end
    foreach (units[i]) push_unit(units[i], i == units.size() - 1);
  endtask

  initial begin
    // Directed: byte-length boundaries
    push_unit(16'h0001, 1'b0);
    push_unit(16'h007F, 1'b0);
    push_unit(16'h0080, 1'b0);
    push_unit(16'h07FF, 1'b0);
    push_unit(16'h0800, 1'b0);
    push_unit(16'hD7FF, 1'b0);
    push_unit(16'hE000, 1'b0);
    push_unit(16'hFFFF, 1'b1);
    // Zero units: dropped, and an end-of-string zero produces nothing
    push_unit(16'h0000, 1'b0);
    push_unit(16'h0000, 1'b1);
    // Surrogate pairs at both extremes, the second ending its string
    push_unit(16'hD800, 1'b0);
    push_unit(16'hDC00, 1'b0);
    push_unit(16'hDBFF, 1'b0);
    push_unit(16'hDFFF, 1'b1);
    // Held high surrogate flushed by a plain unit, then by another high
    push_unit(16'hD9AB, 1'b0);
    push_unit(16'h0041, 1'b0);
    push_unit(16'hDA00, 1'b0);
    push_unit(16'hDB55, 1'b0);
    push_unit(16'hDE21, 1'b0);
    // Held high surrogate flushed by a zero that ends the string
    push_unit(16'hD800, 1'b0);
    push_unit(16'h0000, 1'b1);
    // High surrogate on the last unit, then lone low surrogates
    push_unit(16'hDBFF, 1'b1);
    push_unit(16'hDC00, 1'b0);
    push_unit(16'hDFFF, 1'b1);
    // Held high surrogate flushed by a 3-byte unit: the longest run
    push_unit(16'hDBFF, 1'b0);
    push_unit(16'hFFFF, 1'b1);

    while (pending_units.size() < 26 + RandomUnits) add_random_string();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every unit to go out, then for every byte to come back
    while (pending_units.size() != 0 || src_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    // Catch stray bytes from the final units
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Source driver: hold each request until taken, idle a random gap between
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (src_valid && src_ready) begin
        predict_utf8(src_data);
        // Flip between calm stretches and idling stretches now and then
        if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
        src_gap = src_calm ? 0 : $urandom_range(0, 4);
      end
      if (src_valid && !src_ready) begin
        // Hold the request and its payload until accepted
      end else if (src_gap > 0) begin
        src_gap--;
        src_valid <= 1'b0;
      end else if (pending_units.size() != 0) begin
        src_valid <= 1'b1;
        src_data  <= pending_units.pop_front();
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink monitor: check each accepted byte, stall a random number of cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    u16u8_pkg::out_req_t exp_byte;
    if (rst) begin
      dst_ready <= 1'b0;
      dst_stall = 0;
    end else begin
      if (dst_valid && dst_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte request: expected none, got %h/%b/%b", $time,
                   dst_data.out_byte, dst_data.run_last, dst_data.string_done);
          mismatches++;
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (dst_data.out_byte !== exp_byte.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, got %h", $time,
                     exp_byte.out_byte, dst_data.out_byte);
            mismatches++;
          end
          if (dst_data.run_last !== exp_byte.run_last) begin
            $display("%0t: run_last mismatch: expected %b, got %b", $time,
                     exp_byte.run_last, dst_data.run_last);
            mismatches++;
          end
          if (dst_data.string_done !== exp_byte.string_done) begin
            $display("%0t: string_done mismatch: expected %b, got %b", $time,
                     exp_byte.string_done, dst_data.string_done);
            mismatches++;
          end
        end
        if ($urandom_range(0, 29) == 0) dst_calm = !dst_calm;
        dst_stall = dst_calm ? 0 : $urandom_range(0, 4);
      end
      if (dst_stall > 0) begin
        dst_stall--;
        dst_ready <= 1'b0;
      end else begin
        dst_ready <= 1'b1;
      end
    end
  end

  // Give up long after the slowest correct run would have finished
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
